FILE: src/tra_pkg.sv
`timescale 1ns / 1ps
package tra_pkg;

  // Field widths
  localparam int unsigned OP_W    = 8;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned MAG_W   = 7;
  localparam int unsigned NIB_W   = 4;
  localparam int unsigned PROD_W  = 16;
  localparam int unsigned MPROD_W = 14;
  localparam int unsigned LPROD_W = 8;

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 24;

  // Shared shift-add / restoring divide unit: one bit per step
  localparam int unsigned STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_LAST = 3'd7;
  localparam logic [STEP_W-1:0] STEP_MAG_END = 3'd7;
  localparam logic [STEP_W-1:0] STEP_NIB_END = 3'd4;

  // Opcodes
  localparam logic [OP_W-1:0] OPC_ADD  = 8'h0C;
  localparam logic [OP_W-1:0] OPC_SUB  = 8'h0D;
  localparam logic [OP_W-1:0] OPC_MUL  = 8'h0E;
  localparam logic [OP_W-1:0] OPC_DIV  = 8'h0F;
  localparam logic [OP_W-1:0] OPC_COPY = 8'h2C;
  localparam logic [OP_W-1:0] OPC_LDI  = 8'h3C;
  localparam logic [OP_W-1:0] OPC_FREE = 8'h4C;

  // Queue
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  typedef enum logic [2:0] {
    K_NOP, K_ADD, K_SUB, K_MUL, K_DIV, K_COPY, K_LDI, K_FREE
  } op_kind_e;

  typedef enum logic [1:0] {
    BS_IDLE, BS_READ, BS_ITER, BS_DONE
  } back_state_e;

  // Classified instruction handed from front to back
  typedef struct packed {
    op_kind_e          kind;
    logic [IDX_W-1:0]  dest;
    logic [IDX_W-1:0]  src;
    logic              dest_ok;
    logic              src_ok;
  } item_t;

  // Result, write_enable in the lowest bit
  typedef struct packed {
    logic              div_by_zero;
    logic              half_flag;
    logic              sign_flag;
    logic              overflow_flag;
    logic              negative_flag;
    logic              zero_flag;
    logic              carry_flag;
    logic [DATA_W-1:0] written_value;
    logic [IDX_W-1:0]  written_reg;
    logic              write_enable;
  } result_t;

  localparam int unsigned OUT_PAD_W = OUT_TDATA_W - $bits(result_t);

endpackage

FILE: src/tra_ram.sv
`timescale 1ns / 1ps
module tra_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/tra_front.sv
`timescale 1ns / 1ps
module tra_front #(
  parameter int unsigned REG_COUNT = 16
) (
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [tra_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic                             q_full_i,
  output logic                             push_o,
  output tra_pkg::item_t                   item_o
);

  localparam logic [tra_pkg::IDX_W:0] RegCnt = REG_COUNT[tra_pkg::IDX_W:0];

  logic [tra_pkg::OP_W-1:0]  action;
  logic [tra_pkg::IDX_W-1:0] dest_reg;
  logic [tra_pkg::IDX_W-1:0] source_field;
  logic                      dest_ok;
  logic                      src_ok;
  logic                      free_ok;

  assign action       = s_axis_tdata[7:0];
  assign dest_reg     = s_axis_tdata[11:8];
  assign source_field = s_axis_tdata[15:12];

  // Accept whenever the queue has room
  assign s_axis_tready = !q_full_i;
  assign push_o        = s_axis_tvalid && !q_full_i;

  // Range checks against the populated register count
  assign dest_ok = {1'b0, dest_reg} < RegCnt;
  assign src_ok  = {1'b0, source_field} < RegCnt;
  assign free_ok = (dest_reg == '0) && src_ok;

  // Classify the opcode; a free is turned into a plain write of zero to its index
  always_comb begin
    item_o.kind    = tra_pkg::K_NOP;
    item_o.dest    = dest_reg;
    item_o.src     = source_field;
    item_o.dest_ok = dest_ok;
    item_o.src_ok  = src_ok;
    case (action)
      tra_pkg::OPC_ADD:  item_o.kind = tra_pkg::K_ADD;
      tra_pkg::OPC_SUB:  item_o.kind = tra_pkg::K_SUB;
      tra_pkg::OPC_MUL:  item_o.kind = tra_pkg::K_MUL;
      tra_pkg::OPC_DIV:  item_o.kind = tra_pkg::K_DIV;
      tra_pkg::OPC_COPY: item_o.kind = tra_pkg::K_COPY;
      tra_pkg::OPC_LDI:  item_o.kind = tra_pkg::K_LDI;
      tra_pkg::OPC_FREE: begin
        item_o.kind    = free_ok ? tra_pkg::K_FREE : tra_pkg::K_NOP;
        item_o.dest    = source_field;
        item_o.dest_ok = free_ok;
      end
      default: item_o.kind = tra_pkg::K_NOP;
    endcase
  end

endmodule

FILE: src/tra_queue.sv
`timescale 1ns / 1ps
module tra_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tra_pkg::item_t item_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output tra_pkg::item_t item_o
);

  tra_pkg::item_t                entries_q [tra_pkg::QDEPTH];
  logic [tra_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [tra_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [tra_pkg::QCNT_W-1:0]    count_q, count_d;

  assign full_o  = count_q == tra_pkg::QCNT_W'(tra_pkg::QDEPTH);
  assign valid_o = count_q != '0;
  assign item_o  = entries_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q + tra_pkg::QPTR_W'(push_i);
    rd_ptr_d = rd_ptr_q + tra_pkg::QPTR_W'(pop_i);
    count_d  = count_q + tra_pkg::QCNT_W'(push_i) - tra_pkg::QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold queued instructions
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: src/tra_back.sv
`timescale 1ns / 1ps
module tra_back #(
  parameter int unsigned REG_COUNT = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  input  tra_pkg::item_t                  q_item_i,
  output logic                            pop_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [tra_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  tra_pkg::back_state_e state_q, state_d;

  tra_pkg::item_t                 cur_q;
  logic [tra_pkg::DATA_W-1:0]     a_q, b_q;
  logic [tra_pkg::PROD_W-1:0]     acc_q;
  logic [tra_pkg::MPROD_W-1:0]    accm_q;
  logic [tra_pkg::LPROD_W-1:0]    accl_q;
  logic [tra_pkg::STEP_W-1:0]     step_q;
  logic [REG_COUNT-1:0]           vld_q;
  tra_pkg::result_t               out_q;
  logic                           out_valid_q;

  logic                           capture, iter, load, out_free;
  logic [tra_pkg::DATA_W-1:0]     rdata_a, rdata_b;
  logic [tra_pkg::DATA_W-1:0]     opnd_a, opnd_b;
  tra_pkg::result_t               res;

  logic [tra_pkg::MAG_W-1:0]      ma, mb;
  logic [tra_pkg::NIB_W-1:0]      la, lb;
  logic                           bs, a_ge;
  logic [tra_pkg::DATA_W-1:0]     msum;
  logic [tra_pkg::MAG_W-1:0]      mdiff;
  logic                           dsign;
  logic                           sm_z, sm_n, sm_v;
  logic [tra_pkg::DATA_W:0]       usum;
  logic [tra_pkg::NIB_W:0]        lsum;
  logic                           qz;

  logic [tra_pkg::DATA_W:0]       div_sh;
  logic                           div_ge;
  logic [tra_pkg::DATA_W-1:0]     div_rem;

  // Register file: two copies, one read at rd and one at rs
  tra_ram #(.WIDTH(tra_pkg::DATA_W), .DEPTH(REG_COUNT), .AW(AW)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (load && res.write_enable),
    .waddr_i (res.written_reg[AW-1:0]),
    .wdata_i (res.written_value),
    .re_i    (pop_o),
    .raddr_i (q_item_i.dest[AW-1:0]),
    .rdata_o (rdata_a)
  );

  tra_ram #(.WIDTH(tra_pkg::DATA_W), .DEPTH(REG_COUNT), .AW(AW)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (load && res.write_enable),
    .waddr_i (res.written_reg[AW-1:0]),
    .wdata_i (res.written_value),
    .re_i    (pop_o),
    .raddr_i (q_item_i.src[AW-1:0]),
    .rdata_o (rdata_b)
  );

  // Never-written or out-of-range registers read as zero
  assign opnd_a = (cur_q.dest_ok && vld_q[cur_q.dest[AW-1:0]]) ? rdata_a : '0;
  assign opnd_b = (cur_q.src_ok && vld_q[cur_q.src[AW-1:0]]) ? rdata_b : '0;

  assign out_free = !out_valid_q || m_axis_tready;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tra_pkg::BS_IDLE: if (q_valid_i) state_d = tra_pkg::BS_READ;
      tra_pkg::BS_READ: begin
        if (cur_q.kind == tra_pkg::K_MUL || cur_q.kind == tra_pkg::K_DIV) begin
          state_d = tra_pkg::BS_ITER;
        end else begin
          state_d = tra_pkg::BS_DONE;
        end
      end
      tra_pkg::BS_ITER: if (step_q == tra_pkg::STEP_LAST) state_d = tra_pkg::BS_DONE;
      tra_pkg::BS_DONE: if (out_free) state_d = tra_pkg::BS_IDLE;
      default: state_d = tra_pkg::BS_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    pop_o   = 1'b0;
    capture = 1'b0;
    iter    = 1'b0;
    load    = 1'b0;
    case (state_q)
      tra_pkg::BS_IDLE: pop_o   = q_valid_i;
      tra_pkg::BS_READ: capture = 1'b1;
      tra_pkg::BS_ITER: iter    = 1'b1;
      tra_pkg::BS_DONE: load    = out_free;
      default: pop_o = 1'b0;
    endcase
  end

  // Restoring divide step on {remainder, quotient}
  assign div_sh  = {acc_q[15:8], acc_q[7]};
  assign div_ge  = div_sh >= {1'b0, b_q};
  assign div_rem = tra_pkg::DATA_W'(div_sh - {1'b0, b_q});

  // Sign-magnitude add and subtract flags
  assign ma    = a_q[6:0];
  assign mb    = b_q[6:0];
  assign la    = a_q[3:0];
  assign lb    = b_q[3:0];
  assign bs    = b_q[7] ^ (cur_q.kind == tra_pkg::K_SUB);
  assign msum  = {1'b0, ma} + {1'b0, mb};
  assign a_ge  = ma >= mb;
  assign mdiff = a_ge ? (ma - mb) : (mb - ma);
  assign dsign = a_ge ? a_q[7] : bs;
  assign sm_z  = (a_q[7] == bs) ? (msum == '0) : (mdiff == '0);
  assign sm_n  = (a_q[7] == bs) ? (a_q[7] && msum != '0) : (dsign && mdiff != '0);
  assign sm_v  = (a_q[7] == bs) && msum[7];
  assign usum  = {1'b0, a_q} + {1'b0, b_q};
  assign lsum  = {1'b0, la} + {1'b0, lb};
  // Sign-magnitude quotient is zero for a zero magnitude divisor or ma < mb
  assign qz    = (mb == '0) || !a_ge;

  // Form the result from operands and the iteration registers
  always_comb begin
    res = '0;
    case (cur_q.kind)
      tra_pkg::K_ADD: begin
        res.write_enable  = cur_q.dest_ok;
        res.written_value = usum[7:0];
        res.carry_flag    = usum[8];
        res.half_flag     = lsum[4];
        res.zero_flag     = sm_z;
        res.negative_flag = sm_n;
        res.overflow_flag = sm_v;
      end
      tra_pkg::K_SUB: begin
        res.write_enable  = cur_q.dest_ok;
        res.written_value = a_q - b_q;
        res.zero_flag     = sm_z;
        res.negative_flag = sm_n;
        res.overflow_flag = sm_v;
      end
      tra_pkg::K_MUL: begin
        res.write_enable  = cur_q.dest_ok;
        res.written_value = acc_q[7:0];
        res.carry_flag    = |acc_q[15:8];
        res.half_flag     = |accl_q[7:4];
        res.zero_flag     = accm_q == '0;
        res.negative_flag = (a_q[7] ^ b_q[7]) && (accm_q != '0);
        res.overflow_flag = |accm_q[13:7];
      end
      tra_pkg::K_DIV: begin
        if (b_q == '0) begin
          res.div_by_zero = 1'b1;
        end else begin
          res.write_enable  = cur_q.dest_ok;
          res.written_value = acc_q[7:0];
          res.zero_flag     = qz;
          res.negative_flag = (a_q[7] ^ b_q[7]) && !qz;
        end
      end
      tra_pkg::K_COPY: begin
        res.write_enable  = cur_q.dest_ok;
        res.written_value = b_q;
      end
      tra_pkg::K_LDI: begin
        res.write_enable  = cur_q.dest_ok;
        res.written_value = tra_pkg::DATA_W'(cur_q.src);
      end
      tra_pkg::K_FREE: begin
        res.write_enable  = cur_q.dest_ok;
      end
      default: res = '0;
    endcase
    res.sign_flag = res.negative_flag ^ res.overflow_flag;
    if (res.write_enable) begin
      res.written_reg = cur_q.dest;
    end else begin
      res.written_value = '0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tra_pkg::BS_IDLE;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
      step_q      <= '0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (load && res.write_enable) begin
        vld_q[res.written_reg[AW-1:0]] <= 1'b1;
      end
      if (capture) begin
        step_q <= '0;
      end else if (iter) begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  // Datapath: operand capture, one multiply or divide bit per cycle, output hold
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_item_i;
    end
    if (capture) begin
      a_q    <= opnd_a;
      b_q    <= opnd_b;
      acc_q  <= (cur_q.kind == tra_pkg::K_DIV) ? tra_pkg::PROD_W'(opnd_a) : '0;
      accm_q <= '0;
      accl_q <= '0;
    end else if (iter) begin
      if (cur_q.kind == tra_pkg::K_DIV) begin
        acc_q <= div_ge ? {div_rem, acc_q[6:0], 1'b1} : {div_sh[7:0], acc_q[6:0], 1'b0};
      end else if (b_q[step_q]) begin
        acc_q <= acc_q + (tra_pkg::PROD_W'(a_q) << step_q);
        if (step_q < tra_pkg::STEP_MAG_END) begin
          accm_q <= accm_q + (tra_pkg::MPROD_W'(ma) << step_q);
        end
        if (step_q < tra_pkg::STEP_NIB_END) begin
          accl_q <= accl_q + (tra_pkg::LPROD_W'(la) << step_q);
        end
      end
    end
    if (load) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{tra_pkg::OUT_PAD_W{1'b0}}, out_q};

endmodule

FILE: src/tiny_register_alu_core.sv
`timescale 1ns / 1ps
// Executes one instruction per transaction on REG_COUNT 8-bit registers, all zero
// after reset. A front end decodes each transaction into a two-entry queue; the
// back end reads both operands from the register file, runs the instruction and
// holds the result in an output register, so input can keep arriving while a
// result waits. Add, subtract, copy, load-immediate, free and unknown opcodes pass
// the back end's idle, read and done states; multiply and divide also iterate in
// the shared unit, which handles one multiplier or quotient bit per cycle.
// Exactly one result transaction follows every input transaction, in order.
module tiny_register_alu_core #(
  parameter int unsigned REG_COUNT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // action[7:0], dest_reg[11:8], source_field[15:12]
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // write_enable[0], written_reg[4:1], written_value[12:5], carry_flag[13],
  // zero_flag[14], negative_flag[15], overflow_flag[16], sign_flag[17],
  // half_flag[18], div_by_zero[19], zero[23:20]
  output logic [23:0] m_axis_tdata
);

  logic           push, pop, q_full, q_valid;
  tra_pkg::item_t push_item, head_item;

  tra_front #(.REG_COUNT(REG_COUNT)) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full_i      (q_full),
    .push_o        (push),
    .item_o        (push_item)
  );

  tra_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  tra_back #(.REG_COUNT(REG_COUNT)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (head_item),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

FILE: src/tra_checker.sv
`timescale 1ns / 1ps
module tra_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // No write means no register index and no value
  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[12:1] == 12'd0)
    else $error("index or value reported without a write");

  // Sign flag follows negative and overflow
  a_sign_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[17] == (m_axis_tdata[15] ^ m_axis_tdata[16]))
    else $error("sign flag is not N xor V");

  // Divide by zero writes nothing and clears every other flag
  a_div_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[19] |-> !m_axis_tdata[0] && m_axis_tdata[18:13] == 6'd0)
    else $error("divide by zero reported with a write or a flag");

  // Padding above the flags stays zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:20] == 4'd0)
    else $error("padding bits set in a result");

endmodule

bind tiny_register_alu_core tra_checker u_tra_checker (.*);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import tra_pkg::*;

  localparam int unsigned REG_COUNT   = 16;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned SETTLE_CYC  = 24;
  localparam int unsigned PHASE_ITEMS = 217;
  localparam int unsigned DIR_ROWS    = 25;

  // One row of the directed table; known_res is used instead of the predictor when known
  typedef struct {
    logic [OP_W-1:0]  action;
    logic [IDX_W-1:0] dest;
    logic [IDX_W-1:0] src;
    bit               known;
    result_t          known_res;
  } instr_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // action[7:0], dest_reg[11:8], source_field[15:12]
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // write_enable[0], written_reg[4:1], written_value[12:5], carry_flag[13],
  // zero_flag[14], negative_flag[15], overflow_flag[16], sign_flag[17],
  // half_flag[18], div_by_zero[19], zero[23:20]
  logic [23:0] m_axis_tdata;

  logic [DATA_W-1:0] shadow_regs [REG_COUNT];
  result_t           pending_results [$];
  instr_row_t        directed_rows [DIR_ROWS];
  int unsigned       send_idle_pct = 0;
  int unsigned       accept_idle_pct = 0;
  int unsigned       fail_count = 0;

  tiny_register_alu_core #(
    .REG_COUNT(REG_COUNT)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Execute one instruction on the shadow register file and return its result
  function automatic result_t run_instr(input logic [OP_W-1:0] action,
                                        input logic [IDX_W-1:0] rd,
                                        input logic [IDX_W-1:0] rs);
    result_t r;
    logic [DATA_W-1:0] a, b;
    logic [7:0] freed;
    int ua, ub, la, lb, sa, sb, ures, lres, sres;
    r = '0;
    a = (rd < REG_COUNT) ? shadow_regs[rd] : '0;
    b = (rs < REG_COUNT) ? shadow_regs[rs] : '0;
    case (action)
      OPC_ADD, OPC_SUB, OPC_MUL, OPC_DIV: begin
        ua = a;
        ub = b;
        la = a[3:0];
        lb = b[3:0];
        sa = a[7] ? -int'(a[6:0]) : int'(a[6:0]);
        sb = b[7] ? -int'(b[6:0]) : int'(b[6:0]);
        ures = 0;
        lres = 0;
        sres = 0;
        if (action == OPC_DIV && ub == 0) begin
          // Leave the register alone and raise only the divide error
          r.div_by_zero = 1'b1;
        end else begin
          case (action)
            OPC_ADD: begin
              ures = ua + ub;
              lres = la + lb;
              sres = sa + sb;
            end
            OPC_SUB: begin
              ures = (ua - ub) & 255;
              sres = sa - sb;
            end
            OPC_MUL: begin
              ures = ua * ub;
              lres = la * lb;
              sres = sa * sb;
            end
            default: begin
              ures = ua / ub;
              lres = (lb != 0) ? la / lb : 0;
              sres = (sb != 0) ? sa / sb : 0;
            end
          endcase
          r.carry_flag    = ures > 255;
          r.zero_flag     = sres == 0;
          r.negative_flag = sres < 0;
          r.overflow_flag = (sres < -127) || (sres > 127);
          r.sign_flag     = r.negative_flag ^ r.overflow_flag;
          r.half_flag     = lres > 15;
          if (rd < REG_COUNT) begin
            shadow_regs[rd] = ures[7:0];
            r.write_enable  = 1'b1;
            r.written_reg   = rd;
            r.written_value = ures[7:0];
          end
        end
      end
      OPC_COPY, OPC_LDI: begin
        if (rd < REG_COUNT) begin
          r.write_enable  = 1'b1;
          r.written_reg   = rd;
          r.written_value = (action == OPC_COPY) ? b : {4'd0, rs};
          shadow_regs[rd] = r.written_value;
        end
      end
      OPC_FREE: begin
        freed = {rd, rs};
        if (freed < REG_COUNT) begin
          shadow_regs[freed[3:0]] = '0;
          r.write_enable = 1'b1;
          r.written_reg  = freed[3:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic result_t known_res(input logic we, input logic [IDX_W-1:0] rg,
                                        input logic [DATA_W-1:0] val, input logic z,
                                        input logic dz);
    result_t r;
    r = '0;
    r.write_enable  = we;
    r.written_reg   = rg;
    r.written_value = val;
    r.zero_flag     = z;
    r.div_by_zero   = dz;
    return r;
  endfunction

  function automatic instr_row_t instr_row(input logic [OP_W-1:0] action,
                                           input logic [IDX_W-1:0] dest,
                                           input logic [IDX_W-1:0] src,
                                           input bit known = 1'b0,
                                           input result_t res = '0);
    instr_row_t row;
    row.action    = action;
    row.dest      = dest;
    row.src       = src;
    row.known     = known;
    row.known_res = res;
    return row;
  endfunction

  // Mostly well-formed instructions, some free on a far index, some random opcodes
  function automatic instr_row_t random_instr();
    int unsigned pick;
    instr_row_t row;
    pick = $urandom_range(99);
    row = instr_row(OP_W'($urandom_range(255)), IDX_W'($urandom_range(15)),
                    IDX_W'($urandom_range(15)));
    if (pick < 14) row.action = OPC_LDI;
    else if (pick < 28) row.action = OPC_ADD;
    else if (pick < 40) row.action = OPC_SUB;
    else if (pick < 54) row.action = OPC_MUL;
    else if (pick < 68) row.action = OPC_DIV;
    else if (pick < 78) row.action = OPC_COPY;
    else if (pick < 88) begin
      row.action = OPC_FREE;
      if ($urandom_range(4) != 0) row.dest = '0;
    end
    return row;
  endfunction

  function automatic string res_text(input result_t r);
    return $sformatf("we=%0b reg=%0d val=%02h C=%0b Z=%0b N=%0b V=%0b S=%0b H=%0b DZ=%0b",
                     r.write_enable, r.written_reg, r.written_value, r.carry_flag,
                     r.zero_flag, r.negative_flag, r.overflow_flag, r.sign_flag,
                     r.half_flag, r.div_by_zero);
  endfunction

  // Drive one transaction, starting and ending at a falling edge
  task automatic send_instr(input instr_row_t row);
    result_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {row.src, row.dest, row.action};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    pred = run_instr(row.action, row.dest, row.src);
    pending_results.push_back(row.known ? row.known_res : pred);
    @(negedge clk_i);
  endtask

  // Receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= accept_idle_pct);
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin : result_check
    result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result: %s", res_text(got));
      end else begin
        want = pending_results.pop_front();
        if (got !== want || m_axis_tdata[23:$bits(result_t)] !== '0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch: expected %s", res_text(want));
            $display("          actual   %s pad=%h", res_text(got),
                     m_axis_tdata[23:$bits(result_t)]);
          end
        end
      end
    end
  end

  // End the run when no transaction moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    foreach (shadow_regs[i]) shadow_regs[i] = '0;

    // Registers start at zero; then build extremes such as 0xFF, 0x80 and overflowing sums
    directed_rows[0]  = instr_row(OPC_ADD, 4'd0, 4'd1, 1'b1,
                                  known_res(1'b1, 4'd0, 8'd0, 1'b1, 1'b0));
    directed_rows[1]  = instr_row(OPC_DIV, 4'd2, 4'd3, 1'b1,
                                  known_res(1'b0, 4'd0, 8'd0, 1'b0, 1'b1));
    directed_rows[2]  = instr_row(8'hFF, 4'd15, 4'd15, 1'b1, '0);
    directed_rows[3]  = instr_row(8'h00, 4'd0, 4'd0, 1'b1, '0);
    directed_rows[4]  = instr_row(OPC_LDI, 4'd1, 4'd15, 1'b1,
                                  known_res(1'b1, 4'd1, 8'd15, 1'b0, 1'b0));
    directed_rows[5]  = instr_row(OPC_LDI, 4'd15, 4'd0, 1'b1,
                                  known_res(1'b1, 4'd15, 8'd0, 1'b0, 1'b0));
    directed_rows[6]  = instr_row(OPC_COPY, 4'd2, 4'd1);
    directed_rows[7]  = instr_row(OPC_ADD, 4'd1, 4'd2);
    directed_rows[8]  = instr_row(OPC_MUL, 4'd1, 4'd1);
    directed_rows[9]  = instr_row(OPC_LDI, 4'd3, 4'd0, 1'b1,
                                  known_res(1'b1, 4'd3, 8'd0, 1'b0, 1'b0));
    directed_rows[10] = instr_row(OPC_LDI, 4'd4, 4'd1, 1'b1,
                                  known_res(1'b1, 4'd4, 8'd1, 1'b0, 1'b0));
    directed_rows[11] = instr_row(OPC_SUB, 4'd3, 4'd4);
    directed_rows[12] = instr_row(OPC_LDI, 4'd5, 4'd8, 1'b1,
                                  known_res(1'b1, 4'd5, 8'd8, 1'b0, 1'b0));
    directed_rows[13] = instr_row(OPC_LDI, 4'd6, 4'd8, 1'b1,
                                  known_res(1'b1, 4'd6, 8'd8, 1'b0, 1'b0));
    directed_rows[14] = instr_row(OPC_MUL, 4'd5, 4'd6);
    directed_rows[15] = instr_row(OPC_ADD, 4'd5, 4'd5);
    // Divisor 0x80: signed zero and nibble zero at once
    directed_rows[16] = instr_row(OPC_DIV, 4'd3, 4'd5);
    directed_rows[17] = instr_row(OPC_ADD, 4'd3, 4'd3);
    directed_rows[18] = instr_row(OPC_SUB, 4'd5, 4'd3);
    directed_rows[19] = instr_row(OPC_DIV, 4'd1, 4'd2);
    directed_rows[20] = instr_row(OPC_COPY, 4'd15, 4'd3);
    // Free inside the file, just past it, and at the far end of the index range
    directed_rows[21] = instr_row(OPC_FREE, 4'd0, 4'd3, 1'b1,
                                  known_res(1'b1, 4'd3, 8'd0, 1'b0, 1'b0));
    directed_rows[22] = instr_row(OPC_FREE, 4'd1, 4'd0, 1'b1, '0);
    directed_rows[23] = instr_row(OPC_FREE, 4'd15, 4'd15, 1'b1, '0);
    directed_rows[24] = instr_row(OPC_DIV, 4'd14, 4'd15);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Sender idles less than the receiver
    send_idle_pct   = 34;
    accept_idle_pct = 69;
    foreach (directed_rows[i]) send_instr(directed_rows[i]);
    repeat (PHASE_ITEMS) send_instr(random_instr());

    // Sender idles more than the receiver
    send_idle_pct   = 69;
    accept_idle_pct = 34;
    repeat (PHASE_ITEMS) send_instr(random_instr());

    // Full rate on both sides
    send_idle_pct   = 0;
    accept_idle_pct = 0;
    repeat (PHASE_ITEMS) send_instr(random_instr());
    s_axis_tvalid <= 1'b0;

    // Drain, then allow the back end to settle
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/tra_pkg.sv
src/tra_ram.sv
src/tra_front.sv
src/tra_queue.sv
src/tra_back.sv
src/tiny_register_alu_core.sv
src/tra_checker.sv
tb/testbench.sv
